// ===== src/crbu_pkg.sv =====
// ----------------------------------------------------------------------------
// crbu_pkg: shared types and constants
// Widths, value-source codes and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package crbu_pkg;
  localparam int BIN_COUNT_DEF  = 256;
  localparam int BIN_SHIFT_DEF  = 8;
  localparam int COUNT_BITS_DEF = 32;
  localparam int SUM_W  = 64;
  localparam int RESP_W = 48;
  localparam int PIX_W  = 16;
  localparam int IRR_W  = 24;

  localparam logic [1:0] SRC_MEASURED     = 2'd0;
  localparam logic [1:0] SRC_EXTRAPOLATED = 2'd1;
  localparam logic [1:0] SRC_UNDEFINED    = 2'd2;

  typedef struct packed {
    logic acc_rd;     // read bin for accumulate
    logic acc_wr;     // write back accumulated bin
    logic ro_rd;      // read bin at readout pointer
    logic div_start;  // start divider
    logic ro_finish;  // form result, advance pointer
    logic clr_step;   // clear one entry
    logic clr_begin;  // start clear sweep
  } crbu_cmd_t;

  typedef struct packed {
    logic div_done;
    logic count_zero;
    logic clr_last;
  } crbu_sts_t;
endpackage

// ===== src/crbu_if.sv =====
// ----------------------------------------------------------------------------
// crbu_in_if / crbu_out_if: handshake channels
// Valid/ready channels carrying pixel items and response results.
// ----------------------------------------------------------------------------
interface crbu_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] pixel_value;
  logic        pixel_enable;
  logic [23:0] irradiance_estimate;
  logic [23:0] exposure_time;
  modport source(output valid, mode, pixel_value, pixel_enable, irradiance_estimate,
                 exposure_time, input ready);
  modport sink(input valid, mode, pixel_value, pixel_enable, irradiance_estimate,
               exposure_time, output ready);
endinterface

interface crbu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  bin_index;
  logic signed [47:0] response_value;
  logic [1:0]  value_source;
  logic        last_bin;
  modport source(output valid, bin_index, response_value, value_source, last_bin,
                 input ready);
  modport sink(input valid, bin_index, response_value, value_source, last_bin,
               output ready);
endinterface

// ===== src/crbu_ctrl.sv =====
// ----------------------------------------------------------------------------
// crbu_ctrl: sequencing controller
// Steps accumulate, readout, division and clear sweep; owns the input handshake.
// ----------------------------------------------------------------------------
module crbu_ctrl import crbu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_mode,
  output logic      in_ready,
  input  logic      out_busy,
  input  logic      last_ro,
  input  crbu_sts_t sts,
  output crbu_cmd_t cmd
);
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_ACC, S_RO_RD, S_RO_DIV, S_RO_FIN}
    state_t;
  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = !(in_mode && out_busy);
        if (in_valid && in_ready) begin
          if (in_mode) begin
            cmd.ro_rd = 1'b1;
            state_nxt = S_RO_RD;
          end else begin
            cmd.acc_rd = 1'b1;
            state_nxt = S_ACC;
          end
        end
      end
      S_ACC: begin
        cmd.acc_wr = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RO_RD: begin
        if (sts.count_zero) begin
          state_nxt = S_RO_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = S_RO_DIV;
        end
      end
      S_RO_DIV: begin
        if (sts.div_done) state_nxt = S_RO_FIN;
      end
      S_RO_FIN: begin
        cmd.ro_finish = 1'b1;
        if (last_ro) begin
          cmd.clr_begin = 1'b1;
          state_nxt = S_CLEAR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end
endmodule

// ===== src/crbu_dp.sv =====
// ----------------------------------------------------------------------------
// crbu_dp: bin stores and arithmetic
// Sum and count memories, product, restoring divider, extrapolation, output.
// ----------------------------------------------------------------------------
module crbu_dp import crbu_pkg::*; #(
  parameter int BIN_COUNT  = BIN_COUNT_DEF,
  parameter int BIN_SHIFT  = BIN_SHIFT_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  crbu_cmd_t         cmd,
  output crbu_sts_t         sts,
  input  logic [PIX_W-1:0]  pixel_value,
  input  logic              pixel_enable,
  input  logic [IRR_W-1:0]  irradiance_estimate,
  input  logic [IRR_W-1:0]  exposure_time,
  input  logic              out_ready,
  output logic              out_busy,
  output logic              last_ro,
  output logic              out_valid,
  output logic [7:0]        out_bin_index,
  output logic signed [RESP_W-1:0] out_response_value,
  output logic [1:0]        out_value_source,
  output logic              out_last_bin
);
  localparam int AW = $clog2(BIN_COUNT);
  localparam int BW = PIX_W + 1;
  localparam logic [AW-1:0] TOP = AW'(BIN_COUNT - 1);
  localparam int DCW = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]      sum_mem [BIN_COUNT];
  logic [COUNT_BITS-1:0] cnt_mem [BIN_COUNT];
  logic [SUM_W-1:0]      sum_q_r;
  logic [COUNT_BITS-1:0] cnt_q_r;
  logic [AW-1:0]         addr_r, ptr_r, clr_r;
  logic                  acc_ok_r;
  logic [2*IRR_W-1:0]    prod_r;

  logic [BW-1:0] bin_full;
  assign bin_full = BW'(pixel_value >> BIN_SHIFT);

  // memory: one read, one write per cycle
  logic              we;
  logic [AW-1:0]     wa;
  logic [SUM_W-1:0]  wsum;
  logic [COUNT_BITS-1:0] wcnt;
  logic [SUM_W:0]    sum_add;
  assign sum_add = {1'b0, sum_q_r} + {{(SUM_W + 1 - 2*IRR_W){1'b0}}, prod_r};

  always_comb begin
    we = 1'b0;
    wa = addr_r;
    wsum = '0;
    wcnt = '0;
    if (cmd.clr_step) begin
      we = 1'b1;
      wa = clr_r;
    end else if (cmd.acc_wr && acc_ok_r) begin
      we = 1'b1;
      wsum = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      wcnt = (&cnt_q_r) ? cnt_q_r : cnt_q_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      sum_mem[wa] <= wsum;
      cnt_mem[wa] <= wcnt;
    end
    if (cmd.acc_rd || cmd.ro_rd) begin
      sum_q_r <= sum_mem[cmd.ro_rd ? ptr_r : AW'(bin_full)];
      cnt_q_r <= cnt_mem[cmd.ro_rd ? ptr_r : AW'(bin_full)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_rd) begin
      addr_r   <= AW'(bin_full);
      acc_ok_r <= pixel_enable && (bin_full < BW'(BIN_COUNT - 1));
      prod_r   <= irradiance_estimate * exposure_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr_begin) clr_r <= '0;
    else if (cmd.clr_step) clr_r <= clr_r + 1'b1;
  end
  assign sts.clr_last = (clr_r == TOP);

  // restoring divider, one quotient bit a cycle
  logic [SUM_W-1:0]      quo_r;
  logic [COUNT_BITS:0]   rem_r;
  logic [DCW-1:0]        dcnt_r;
  logic                  dbusy_r;
  logic [COUNT_BITS:0]   rem_sh, rem_sub;
  assign rem_sh  = {rem_r[COUNT_BITS-1:0], quo_r[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, cnt_q_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1;
      quo_r   <= sum_q_r;
      rem_r   <= '0;
      dcnt_r  <= DCW'(SUM_W);
    end else if (dbusy_r) begin
      if (rem_sub[COUNT_BITS]) begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[SUM_W-2:0], 1'b0};
      end else begin
        rem_r <= rem_sub;
        quo_r <= {quo_r[SUM_W-2:0], 1'b1};
      end
      dcnt_r <= dcnt_r - 1'b1;
      if (dcnt_r == DCW'(1)) dbusy_r <= 1'b0;
    end
  end
  assign sts.div_done   = !dbusy_r && !cmd.div_start;
  assign sts.count_zero = (cnt_q_r == '0);
  assign last_ro        = (ptr_r == TOP);

  // result forming
  logic signed [RESP_W-1:0] prior0_r, prior1_r, value;
  logic                     def0_r, def1_r, defined;
  logic [1:0]               source;
  logic signed [RESP_W+1:0] ext;
  assign ext = 3'sd2 * (RESP_W + 2)'(prior1_r) - (RESP_W + 2)'(prior0_r);

  always_comb begin
    if (!sts.count_zero) begin
      value = (|quo_r[SUM_W-1:RESP_W-1]) ? {1'b0, {(RESP_W-1){1'b1}}}
                                          : RESP_W'(quo_r);
      source = SRC_MEASURED;
      defined = 1'b1;
    end else if (ptr_r > AW'(1)) begin
      if (ext > (RESP_W + 2)'(signed'({1'b0, {(RESP_W-1){1'b1}}})))
        value = {1'b0, {(RESP_W-1){1'b1}}};
      else if (ext < -(RESP_W + 2)'(signed'({1'b0, {(RESP_W-1){1'b1}}})) - 1)
        value = {1'b1, {(RESP_W-1){1'b0}}};
      else
        value = RESP_W'(ext);
      defined = def0_r && def1_r;
      source = defined ? SRC_EXTRAPOLATED : SRC_UNDEFINED;
    end else begin
      value = '0;
      source = SRC_UNDEFINED;
      defined = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      prior0_r <= '0;
      prior1_r <= '0;
      def0_r <= 1'b0;
      def1_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.ro_finish) begin
        out_valid          <= 1'b1;
        out_bin_index      <= 8'(ptr_r);
        out_response_value <= value;
        out_value_source   <= source;
        out_last_bin       <= last_ro;
        if (last_ro) begin
          ptr_r <= '0;
          prior0_r <= '0;
          prior1_r <= '0;
          def0_r <= 1'b0;
          def1_r <= 1'b0;
        end else begin
          ptr_r <= ptr_r + 1'b1;
          prior0_r <= prior1_r;
          def0_r <= def1_r;
          prior1_r <= value;
          def1_r <= defined;
        end
      end
    end
  end
  assign out_busy = out_valid && !out_ready;
endmodule

// ===== src/camera_response_bin_update_top.sv =====
// ----------------------------------------------------------------------------
// camera_response_bin_update_top: inverse camera response bin update
// Accumulates pixel irradiance x exposure per bin; reads bins out as averages,
// extrapolating empty bins from the two bins before them.
// Input channel in_*: mode 0 accumulates one enabled pixel into the bin selected
// by its upper bits (top bin dropped); mode 1 reads out the next bin on out_*.
// An accumulate transaction reads the bin memory, then writes it back.
// A readout of a filled bin runs the one-bit-a-cycle restoring divider over the
// 64-bit sum; a readout of an empty bin skips the division.
// Results sit in an output register; a further accumulate is taken while it
// waits, a further readout waits until it has been taken.
// After reset, and after the top bin is read out, a clearing pass walks the
// bin memories one entry a cycle with in_ready low.
// ----------------------------------------------------------------------------
module camera_response_bin_update_top import crbu_pkg::*; #(
  parameter int BIN_COUNT  = BIN_COUNT_DEF,
  parameter int BIN_SHIFT  = BIN_SHIFT_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  crbu_in_if.sink    in_ch,
  crbu_out_if.source out_ch
);
  crbu_cmd_t cmd;
  crbu_sts_t sts;
  logic      out_busy, last_ro;

  crbu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_mode(in_ch.mode),
    .in_ready(in_ch.ready), .out_busy(out_busy), .last_ro(last_ro),
    .sts(sts), .cmd(cmd)
  );

  crbu_dp #(.BIN_COUNT(BIN_COUNT), .BIN_SHIFT(BIN_SHIFT), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .pixel_value(in_ch.pixel_value), .pixel_enable(in_ch.pixel_enable),
    .irradiance_estimate(in_ch.irradiance_estimate),
    .exposure_time(in_ch.exposure_time), .out_ready(out_ch.ready),
    .out_busy(out_busy), .last_ro(last_ro), .out_valid(out_ch.valid),
    .out_bin_index(out_ch.bin_index), .out_response_value(out_ch.response_value),
    .out_value_source(out_ch.value_source), .out_last_bin(out_ch.last_bin)
  );

  a_no_ro_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ro_finish |-> !out_busy) else $error("result overwritten");
  a_undef_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.value_source == SRC_MEASURED ||
                      out_ch.value_source == SRC_EXTRAPOLATED ||
                      out_ch.value_source == SRC_UNDEFINED))
    else $error("bad source code");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.acc_rd, cmd.acc_wr, cmd.ro_rd, cmd.ro_finish, cmd.clr_step}))
    else $error("conflicting commands");
endmodule

// ===== tb/camera_response_bin_update_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// camera_response_bin_update_top_tb: self-checking bench for the bin update
// Drives pixel accumulate and bin readout transactions under varying idle and
// back-pressure, predicts each response bin from a behavioural copy of the
// bin stores and checks every result transaction field by field.
// ----------------------------------------------------------------------------
module camera_response_bin_update_top_tb;
  import crbu_pkg::*;

  localparam longint RESP_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint RESP_MIN = -RESP_MAX - 1;
  localparam bit     MODE_ACC = 1'b0;
  localparam bit     MODE_READ = 1'b1;

  typedef struct {
    bit        mode;
    bit [15:0] pixel_value;
    bit        pixel_enable;
    bit [23:0] irradiance_estimate;
    bit [23:0] exposure_time;
  } pixel_txn_t;

  typedef struct {
    bit [7:0]  bin_index;
    bit [47:0] response_value;
    bit [1:0]  value_source;
    bit        last_bin;
  } response_t;

  logic clk;
  logic rst_n;

  crbu_in_if  in_ch();
  crbu_out_if out_ch();

  camera_response_bin_update_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bit [63:0] bin_sum [256];
  bit [31:0] bin_cnt [256];
  bit [7:0]  read_ptr;
  longint    prev_resp [2];
  bit        prev_def [2];

  response_t expected_responses [$];
  int        errors;
  int        src_idle;
  int        snk_idle;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  task automatic clear_bins();
    foreach (bin_sum[i]) begin
      bin_sum[i] = '0;
      bin_cnt[i] = '0;
    end
    read_ptr = '0;
    prev_resp[0] = 0;
    prev_resp[1] = 0;
    prev_def[0] = 1'b0;
    prev_def[1] = 1'b0;
  endtask

  task automatic update_bins(pixel_txn_t t);
    bit [7:0]  b;
    bit [63:0] prod;
    bit [63:0] q;
    longint    v;
    bit        def;
    response_t r;
    if (t.mode == MODE_ACC) begin
      b = t.pixel_value[15:8];
      if (t.pixel_enable && b != 8'd255) begin
        prod = 64'(t.irradiance_estimate) * 64'(t.exposure_time);
        bin_sum[b] = (bin_sum[b] > ~64'd0 - prod) ? ~64'd0 : bin_sum[b] + prod;
        if (bin_cnt[b] != ~32'd0) bin_cnt[b] = bin_cnt[b] + 1;
      end
    end else begin
      v = 0;
      def = 1'b0;
      if (bin_cnt[read_ptr] != 0) begin
        q = bin_sum[read_ptr] / 64'(bin_cnt[read_ptr]);
        v = (q > 64'(RESP_MAX)) ? RESP_MAX : longint'(q);
        def = 1'b1;
        r.value_source = SRC_MEASURED;
      end else if (read_ptr > 1) begin
        v = 2 * prev_resp[1] - prev_resp[0];
        if (v > RESP_MAX) v = RESP_MAX;
        if (v < RESP_MIN) v = RESP_MIN;
        def = prev_def[0] && prev_def[1];
        r.value_source = def ? SRC_EXTRAPOLATED : SRC_UNDEFINED;
      end else begin
        r.value_source = SRC_UNDEFINED;
      end
      r.bin_index = read_ptr;
      r.response_value = v[47:0];
      r.last_bin = (read_ptr == 8'd255);
      expected_responses.push_back(r);
      if (r.last_bin) begin
        clear_bins();
      end else begin
        prev_resp[0] = prev_resp[1];
        prev_def[0] = prev_def[1];
        prev_resp[1] = v;
        prev_def[1] = def;
        read_ptr = read_ptr + 1;
      end
    end
  endtask

  task automatic send_pixel(pixel_txn_t t);
    if ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= t.mode;
    in_ch.pixel_value <= t.pixel_value;
    in_ch.pixel_enable <= t.pixel_enable;
    in_ch.irradiance_estimate <= t.irradiance_estimate;
    in_ch.exposure_time <= t.exposure_time;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    update_bins(t);
  endtask

  task automatic send_acc(bit [15:0] pix, bit en, bit [23:0] irr, bit [23:0] expo);
    pixel_txn_t t;
    t.mode = MODE_ACC;
    t.pixel_value = pix;
    t.pixel_enable = en;
    t.irradiance_estimate = irr;
    t.exposure_time = expo;
    send_pixel(t);
  endtask

  task automatic send_read();
    pixel_txn_t t;
    t.mode = MODE_READ;
    t.pixel_value = $urandom;
    t.pixel_enable = $urandom;
    t.irradiance_estimate = $urandom;
    t.exposure_time = $urandom;
    send_pixel(t);
  endtask

  // empty, saturated, extrapolated and negatively saturated bins
  task automatic test_bin_extremes();
    src_idle = 0;
    snk_idle = 0;
    send_acc(16'h01FF, 1'b1, 24'hFFFFFF, 24'hFFFFFF);
    send_acc(16'h0200, 1'b1, 24'h000000, 24'hFFFFFF);
    send_acc(16'hFFFF, 1'b1, 24'hFFFFFF, 24'hFFFFFF);
    send_acc(16'h0500, 1'b0, 24'hFFFFFF, 24'hFFFFFF);
    send_acc(16'h0555, 1'b1, 24'h123456, 24'h000001);
    send_acc(16'h05AA, 1'b1, 24'h000FFF, 24'h010000);
    send_acc(16'hFE00, 1'b1, 24'h800000, 24'h000800);
    repeat (7) send_read();
  endtask

  task automatic test_random(int n, int s_idle, int k_idle);
    pixel_txn_t t;
    src_idle = s_idle;
    snk_idle = k_idle;
    repeat (n) begin
      t.mode = ($urandom_range(99) < 40) ? MODE_READ : MODE_ACC;
      t.pixel_value = $urandom;
      if ($urandom_range(3) == 0) t.pixel_value[15:8] = $urandom_range(0, 7);
      t.pixel_enable = ($urandom_range(99) < 85);
      t.irradiance_estimate = $urandom;
      t.exposure_time = $urandom;
      case ($urandom_range(9))
        0: t.irradiance_estimate = '0;
        1: t.exposure_time = '1;
        2: t.irradiance_estimate = '1;
        default: ;
      endcase
      send_pixel(t);
    end
  endtask

  always @(posedge clk) begin
    response_t e;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_responses.size() == 0) begin
        errors++;
        $display("%0t unexpected result: bin %0d value %0d source %0d last %0d", $time,
                 out_ch.bin_index, out_ch.response_value, out_ch.value_source,
                 out_ch.last_bin);
      end else begin
        e = expected_responses.pop_front();
        if (out_ch.bin_index !== e.bin_index || out_ch.response_value !== e.response_value ||
            out_ch.value_source !== e.value_source || out_ch.last_bin !== e.last_bin) begin
          errors++;
          $display("%0t mismatch: expected bin %0d value %0d source %0d last %0d", $time,
                   e.bin_index, $signed(e.response_value), e.value_source, e.last_bin);
          $display("%0t           actual   bin %0d value %0d source %0d last %0d", $time,
                   out_ch.bin_index, out_ch.response_value, out_ch.value_source,
                   out_ch.last_bin);
        end
      end
    end
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= snk_idle);
  end

  initial begin
    #4_000_000;
    $display("** camera_response_bin_update_top: FAILED **");
    $finish;
  end

  initial begin
    errors = 0;
    src_idle = 0;
    snk_idle = 0;
    clear_bins();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_ACC;
    in_ch.pixel_value = '0;
    in_ch.pixel_enable = 1'b0;
    in_ch.irradiance_estimate = '0;
    in_ch.exposure_time = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_bin_extremes();
    test_random(200, 0, 0);
    test_random(180, 73, 0);
    test_random(180, 0, 73);
    test_random(180, 7, 7);
    in_ch.valid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("** camera_response_bin_update_top: PASSED **");
    end else begin
      $display("** camera_response_bin_update_top: FAILED **");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/crbu_pkg.sv
src/crbu_if.sv
src/crbu_ctrl.sv
src/crbu_dp.sv
src/camera_response_bin_update_top.sv
tb/camera_response_bin_update_top_tb.sv
